### sv/blm_pkg.sv
package blm_pkg;

	// Field widths
	localparam int MV_W    = 14;
	localparam int LEVEL_W = 2;
	localparam int SUM_W   = 20;

	// Stream widths: payload rounded up to whole bytes
	localparam int S_DATA_BITS = 4 * MV_W;
	localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = LEVEL_W + 3 + MV_W;
	localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

	localparam int AVG_WINDOW_DEF = 8;

	localparam logic [MV_W-1:0] MV_MAX = '1;

	// Item kinds
	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Voltage thresholds, mV
	localparam logic [MV_W-1:0] MV_FAULT    = 14'd2700;
	localparam logic [MV_W-1:0] MV_2800     = 14'd2800;
	localparam logic [MV_W-1:0] MV_2900     = 14'd2900;
	localparam logic [MV_W-1:0] MV_3000     = 14'd3000;
	localparam logic [MV_W-1:0] MV_3200     = 14'd3200;
	localparam logic [MV_W-1:0] MV_3500     = 14'd3500;
	localparam logic [MV_W-1:0] MV_3600     = 14'd3600;
	localparam logic [MV_W-1:0] MV_3800     = 14'd3800;

	// Converter saturation: out * SAT_NUM > pack * SAT_DEN
	localparam int SAT_W = MV_W + 7;
	localparam logic [6:0] SAT_NUM = 7'd100;
	localparam logic [6:0] SAT_DEN = 7'd87;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_PLENTY = 2'd0,
		LVL_MID    = 2'd1,
		LVL_LOW    = 2'd2,
		LVL_VLOW   = 2'd3
	} level_t;

	typedef struct packed {
		logic            kind;
		logic [MV_W-1:0] cell_voltage_mv;
		logic [MV_W-1:0] pack_voltage_mv;
		logic [MV_W-1:0] output_voltage_mv;
		logic [MV_W-1:0] alert_threshold_mv;
	} item_t;

	typedef struct packed {
		logic [MV_W-1:0] filtered_mv;
		logic            refreshed;
	} filt_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               alert;
		logic               fault;
		logic [MV_W-1:0]    filtered_mv;
		logic               refreshed;
	} result_t;

endpackage

### sv/blm_filter.sv
// Averaging window and trimmed-mean filter.
module blm_filter #(
	parameter int AVG_WINDOW = blm_pkg::AVG_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  blm_pkg::item_t      item,
	output blm_pkg::filt_t      filt
);

	localparam int SUM_W = blm_pkg::SUM_W;
	localparam int MV_W  = blm_pkg::MV_W;
	localparam int CNT_W = $clog2(AVG_WINDOW + 1);
	localparam int DIV   = AVG_WINDOW - 2;
	// exact reciprocal: floor(x * MUL / 2^SHIFT) == floor(x / DIV) for x < 2^SUM_W
	localparam int SHIFT = SUM_W + $clog2(DIV);
	localparam int MUL_W = SUM_W + 1;
	localparam longint unsigned MUL_L = ((64'd1 << SHIFT) + DIV - 1) / DIV;
	localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_L);
	localparam int PROD_W = SUM_W + MUL_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(AVG_WINDOW);

	logic [SUM_W-1:0] sum_q, sum_n;
	logic [SUM_W-1:0] rest_q, rest_n;
	logic [MV_W-1:0]  min_q, min_n, max_q, max_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [MV_W-1:0]  filt_q, filt_n;
	logic             refreshed;

	logic [SUM_W-1:0]  acc_sum;
	logic [MV_W-1:0]   acc_min, acc_max;
	logic [MV_W:0]     acc_trim;
	logic [SUM_W-1:0]  acc_rest;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  quot;
	logic [MV_W-1:0]   mean;

	// window update with this sample
	always_comb begin
		acc_sum  = sum_q + SUM_W'(item.cell_voltage_mv);
		acc_min  = (min_q > item.cell_voltage_mv) ? item.cell_voltage_mv : min_q;
		acc_max  = (max_q < item.cell_voltage_mv) ? item.cell_voltage_mv : max_q;
		acc_trim = {1'b0, acc_min} + {1'b0, acc_max};
		acc_rest = (acc_sum >= SUM_W'(acc_trim)) ? acc_sum - SUM_W'(acc_trim) : '0;
	end

	// trimmed mean of a full window; rest_q is kept ready by the accumulate path
	always_comb begin
		prod = PROD_W'(rest_q) * PROD_W'(MUL);
		quot = SUM_W'(prod >> SHIFT);
		mean = (quot > SUM_W'(blm_pkg::MV_MAX)) ? blm_pkg::MV_MAX : quot[MV_W-1:0];
	end

	always_comb begin
		sum_n     = sum_q;
		rest_n    = rest_q;
		min_n     = min_q;
		max_n     = max_q;
		cnt_n     = cnt_q;
		filt_n    = filt_q;
		refreshed = 1'b0;
		if (item.kind == blm_pkg::KIND_START) begin
			filt_n = item.cell_voltage_mv;
			sum_n  = '0;
			rest_n = '0;
			min_n  = blm_pkg::MV_MAX;
			max_n  = '0;
			cnt_n  = '0;
		end else if (cnt_q < CNT_FULL) begin
			sum_n  = acc_sum;
			rest_n = acc_rest;
			min_n  = acc_min;
			max_n  = acc_max;
			cnt_n  = cnt_q + CNT_W'(1);
		end else begin
			filt_n    = mean;
			refreshed = 1'b1;
			sum_n     = '0;
			rest_n    = '0;
			min_n     = blm_pkg::MV_MAX;
			max_n     = '0;
			cnt_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			rest_q <= '0;
			min_q  <= blm_pkg::MV_MAX;
			max_q  <= '0;
			cnt_q  <= '0;
			filt_q <= '0;
		end else if (fire) begin
			sum_q  <= sum_n;
			rest_q <= rest_n;
			min_q  <= min_n;
			max_q  <= max_n;
			cnt_q  <= cnt_n;
			filt_q <= filt_n;
		end
	end

	assign filt.filtered_mv = filt_n;
	assign filt.refreshed   = refreshed;

endmodule

### sv/blm_status.sv
// Alert/fault flags and the hysteretic charge-level state.
module blm_status (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  blm_pkg::item_t     item,
	input  blm_pkg::filt_t     filt,
	output blm_pkg::result_t   result
);

	localparam int MV_W  = blm_pkg::MV_W;
	localparam int SAT_W = blm_pkg::SAT_W;

	blm_pkg::level_t level_q, level_n;

	logic [MV_W-1:0]  v;
	logic [SAT_W-1:0] out_scaled, pack_scaled;
	logic             saturated, alert, fault;

	assign v = filt.filtered_mv;

	always_comb begin
		out_scaled  = SAT_W'(item.output_voltage_mv) * SAT_W'(blm_pkg::SAT_NUM);
		pack_scaled = SAT_W'(item.pack_voltage_mv) * SAT_W'(blm_pkg::SAT_DEN);
		saturated   = out_scaled > pack_scaled;
	end

	always_comb begin
		alert = 1'b0;
		fault = 1'b0;
		if (item.kind == blm_pkg::KIND_SAMPLE && item.alert_threshold_mv != '0) begin
			fault = (v <= blm_pkg::MV_FAULT);
			alert = !fault && (saturated || v <= item.alert_threshold_mv);
		end
	end

	always_comb begin
		level_n = level_q;
		if (item.kind == blm_pkg::KIND_START) begin
			priority if (v < blm_pkg::MV_2900) level_n = blm_pkg::LVL_VLOW;
			else if (v < blm_pkg::MV_3200)     level_n = blm_pkg::LVL_LOW;
			else if (v < blm_pkg::MV_3600)     level_n = blm_pkg::LVL_MID;
			else                               level_n = blm_pkg::LVL_PLENTY;
		end else begin
			unique case (level_q)
				blm_pkg::LVL_PLENTY: begin
					if (v < blm_pkg::MV_3600) level_n = blm_pkg::LVL_MID;
				end
				blm_pkg::LVL_MID: begin
					// deepest drop wins
					priority if (v < blm_pkg::MV_2800) level_n = blm_pkg::LVL_VLOW;
					else if (v < blm_pkg::MV_3200)     level_n = blm_pkg::LVL_LOW;
					else if (v > blm_pkg::MV_3800)     level_n = blm_pkg::LVL_PLENTY;
				end
				blm_pkg::LVL_LOW: begin
					priority if (v < blm_pkg::MV_2900) level_n = blm_pkg::LVL_VLOW;
					else if (v > blm_pkg::MV_3500)     level_n = blm_pkg::LVL_PLENTY;
				end
				blm_pkg::LVL_VLOW: begin
					// recovery goes through low, never straight to plenty
					if (v > blm_pkg::MV_3000) level_n = blm_pkg::LVL_LOW;
				end
				default: level_n = level_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= blm_pkg::LVL_PLENTY;
		end else if (fire) begin
			level_q <= level_n;
		end
	end

	assign result.level       = level_n;
	assign result.alert       = alert;
	assign result.fault       = fault;
	assign result.filtered_mv = filt.filtered_mv;
	assign result.refreshed   = filt.refreshed;

endmodule

### sv/battery_level_monitor.sv
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+------------------------------------------------
// s_axis    | in  | tvalid / tready     | tuser: kind; tdata: cell, pack, output, threshold
// m_axis    | out | tvalid / tready     | tdata: level, alert, fault, filtered_mv, refreshed
//
// One request per cycle sustained while m_axis_tready is high; a request taken into the
// input register moves into the result register once that register is free or draining.
// The accumulate/trim/divide and flag/level logic sits between those two registers;
// the window divide is a single constant-reciprocal multiply.
// arst_n clears the window (min to full scale), filtered value, level and both valids.
// A stalled result holds in the result register while one more request may enter the
// input register; s_axis_tready drops only when both are full and m_axis_tready is low.
module battery_level_monitor #(
	parameter int AVG_WINDOW = blm_pkg::AVG_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [13:0] cell_voltage_mv, [27:14] pack_voltage_mv, [41:28] output_voltage_mv,
	// [55:42] alert_threshold_mv
	input  logic [blm_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] kind
	input  logic [0:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [1:0] level, [2] alert, [3] fault, [17:4] filtered_mv, [18] refreshed, rest zero
	output logic [blm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	localparam int MV_W = blm_pkg::MV_W;

	blm_pkg::item_t   in_item;
	blm_pkg::item_t   item_s1;
	logic             valid_s1;
	blm_pkg::filt_t   filt;
	blm_pkg::result_t result;
	blm_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;
	logic             fire;

	// unpack the request
	assign in_item.kind               = s_axis_tuser[0];
	assign in_item.cell_voltage_mv    = s_axis_tdata[0 +: MV_W];
	assign in_item.pack_voltage_mv    = s_axis_tdata[MV_W +: MV_W];
	assign in_item.output_voltage_mv  = s_axis_tdata[2*MV_W +: MV_W];
	assign in_item.alert_threshold_mv = s_axis_tdata[3*MV_W +: MV_W];

	// result register free or being drained this cycle
	assign advance       = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
		if (fire) begin
			result_s2 <= result;
		end
	end

	// window state and trimmed mean; state commits only on fire
	blm_filter #(
		.AVG_WINDOW(AVG_WINDOW)
	) u_filter (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.filt  (filt)
	);

	// flags and charge level from the new filtered value
	blm_status u_status (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.filt  (filt),
		.result(result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = blm_pkg::M_TDATA_W'({result_s2.refreshed, result_s2.filtered_mv,
		result_s2.fault, result_s2.alert, result_s2.level});

endmodule

### sv/blm_checker.sv
module blm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [blm_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic [0:0]                    s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [blm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	localparam int MV_W = blm_pkg::MV_W;

	logic [1:0]      level;
	logic            alert;
	logic            fault;
	logic [MV_W-1:0] filtered;

	assign level    = m_axis_tdata[1:0];
	assign alert    = m_axis_tdata[2];
	assign fault    = m_axis_tdata[3];
	assign filtered = m_axis_tdata[4 +: MV_W];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input side stalls only behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// fault masks alert and implies a low filtered value
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fault |-> !alert && filtered <= blm_pkg::MV_FAULT)
		else $error("fault inconsistent with alert or voltage");

	// level extremes agree with the filtered value
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(level != blm_pkg::LVL_PLENTY || filtered > blm_pkg::MV_3500) &&
		(level != blm_pkg::LVL_VLOW || filtered <= blm_pkg::MV_3000))
		else $error("level inconsistent with filtered voltage");

	logic unused_ok;
	assign unused_ok = s_axis_tvalid ^ (^s_axis_tdata) ^ s_axis_tuser[0];

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
